// ----- sv/scp_pkg.sv -----
// shared widths and constants for the segment closest points pipeline
`default_nettype none
package scp_pkg;
    localparam int CW        = 24;   // coordinate width
    localparam int DFW       = 25;   // coordinate difference width
    localparam int PRW       = 50;   // product of two differences
    localparam int SW        = 52;   // dot product width
    localparam int XW        = 53;   // dot product sum or difference
    localparam int MW        = 104;  // product of two dot products
    localparam int NWIDE     = 105;  // difference of two such products
    localparam int PARAM_W   = 17;
    localparam int FRAC_SH   = 16;
    localparam int FRAC_QB   = 16;
    localparam int T_QB      = 17;
    localparam int PIPE_LEN  = 47;
    localparam logic [PARAM_W-1:0] PARAM_ONE = 17'h10000;
endpackage
`default_nettype wire

// ----- sv/segment_closest_points.sv -----
// top level of the segment closest points pipeline
//
// Takes one pair of 3D segments (signed Q8.16 endpoints) per clock and returns
// the clamped parameters s and t of their closest points as unsigned Q1.16,
// where 0x10000 means one. The depth is set by the 17-stage divider for s and
// the 18-stage divider for t in series (t is worked out from the quantised s),
// with a 3-stage multiplier in between. The whole pipeline advances together:
// when the output word is held, every stage holds and s_ready goes low,
// nothing is dropped.
`default_nettype none
module segment_closest_points (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg1_start_x,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg1_start_y,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg1_start_z,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg1_end_x,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg1_end_y,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg1_end_z,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg2_start_x,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg2_start_y,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg2_start_z,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg2_end_x,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg2_end_y,
    input  wire logic signed [scp_pkg::CW-1:0]   s_seg2_end_z,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [scp_pkg::PARAM_W-1:0]          m_param_first,
    output logic [scp_pkg::PARAM_W-1:0]          m_param_second
);
    import scp_pkg::*;

    logic                   en;
    logic [PIPE_LEN-1:0]    v_reg;

    logic signed [CW-1:0]   p1 [3], q1 [3], p2 [3], q2 [3];
    logic signed [DFW-1:0]  d1_reg [3], d2_reg [3], r_reg [3];
    logic signed [PRW-1:0]  aa_reg [3], ee_reg [3], ff_reg [3], cc_reg [3], bb_reg [3];
    logic signed [SW-1:0]   a_reg, e_reg, f_reg, c_reg, b_reg;
    logic signed [XW-1:0]   ncm, bmc, fx;

    logic signed [MW-1:0]   ae_p, bb_p, bf_p, ce_p, bs_p;
    logic signed [NWIDE-1:0] den_n, num_n, den_reg, num_reg;
    logic signed [NWIDE-1:0] tn_reg, elim;

    logic [PARAM_W-1:0]     s_q, fc_q, fbc_q, ft_q, t_q;
    logic [PARAM_W-1:0]     s_d, fc_d, fbc_d, ft_d;
    logic signed [SW-1:0]   b_d, f_d, e_d, s_ext;
    logic [1:0]             deg_d, tflag, tflag_d;
    logic [PARAM_W-1:0]     s_sel, t_sel;
    logic [PARAM_W-1:0]     s_out_reg, t_out_reg;

    assign en      = !v_reg[PIPE_LEN-1] || m_ready;
    assign s_ready = en;

    // input word unpacked into vectors
    assign p1[0] = s_seg1_start_x; assign p1[1] = s_seg1_start_y; assign p1[2] = s_seg1_start_z;
    assign q1[0] = s_seg1_end_x;   assign q1[1] = s_seg1_end_y;   assign q1[2] = s_seg1_end_z;
    assign p2[0] = s_seg2_start_x; assign p2[1] = s_seg2_start_y; assign p2[2] = s_seg2_start_z;
    assign q2[0] = s_seg2_end_x;   assign q2[1] = s_seg2_end_y;   assign q2[2] = s_seg2_end_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[PIPE_LEN-2:0], s_valid};
        end
    end

    // differences, products and dot products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                d1_reg[k] <= DFW'(q1[k]) - DFW'(p1[k]);
                d2_reg[k] <= DFW'(q2[k]) - DFW'(p2[k]);
                r_reg[k]  <= DFW'(p1[k]) - DFW'(p2[k]);
                aa_reg[k] <= d1_reg[k] * d1_reg[k];
                ee_reg[k] <= d2_reg[k] * d2_reg[k];
                ff_reg[k] <= d2_reg[k] * r_reg[k];
                cc_reg[k] <= d1_reg[k] * r_reg[k];
                bb_reg[k] <= d1_reg[k] * d2_reg[k];
            end
            a_reg <= SW'(aa_reg[0]) + SW'(aa_reg[1]) + SW'(aa_reg[2]);
            e_reg <= SW'(ee_reg[0]) + SW'(ee_reg[1]) + SW'(ee_reg[2]);
            f_reg <= SW'(ff_reg[0]) + SW'(ff_reg[1]) + SW'(ff_reg[2]);
            c_reg <= SW'(cc_reg[0]) + SW'(cc_reg[1]) + SW'(cc_reg[2]);
            b_reg <= SW'(bb_reg[0]) + SW'(bb_reg[1]) + SW'(bb_reg[2]);
        end
    end

    assign ncm = -XW'(c_reg);
    assign bmc = XW'(b_reg) - XW'(c_reg);
    assign fx  = XW'(f_reg);

    scp_mul #(.W(SW)) u_mul_ae (.aclk(aclk), .en(en), .a(a_reg), .b(e_reg), .p(ae_p));
    scp_mul #(.W(SW)) u_mul_bb (.aclk(aclk), .en(en), .a(b_reg), .b(b_reg), .p(bb_p));
    scp_mul #(.W(SW)) u_mul_bf (.aclk(aclk), .en(en), .a(b_reg), .b(f_reg), .p(bf_p));
    scp_mul #(.W(SW)) u_mul_ce (.aclk(aclk), .en(en), .a(c_reg), .b(e_reg), .p(ce_p));

    // parallel case: numerator forced to zero gives s of zero
    always_comb begin
        den_n = NWIDE'(ae_p) - NWIDE'(bb_p);
        num_n = NWIDE'(bf_p) - NWIDE'(ce_p);
        if (den_n[NWIDE-1] || den_n == '0) begin
            num_n = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_n;
            num_reg <= num_n;
        end
    end

    scp_div #(.NW(NWIDE), .DW(NWIDE), .QB(FRAC_QB), .SH(FRAC_SH), .FRAC(1)) u_div_s (
        .aclk(aclk), .en(en), .num(num_reg), .den(den_reg), .quo(s_q));

    scp_div #(.NW(XW), .DW(SW), .QB(FRAC_QB), .SH(FRAC_SH), .FRAC(1)) u_div_fc (
        .aclk(aclk), .en(en), .num(ncm), .den(a_reg), .quo(fc_q));
    scp_div #(.NW(XW), .DW(SW), .QB(FRAC_QB), .SH(FRAC_SH), .FRAC(1)) u_div_fbc (
        .aclk(aclk), .en(en), .num(bmc), .den(a_reg), .quo(fbc_q));
    scp_div #(.NW(XW), .DW(SW), .QB(FRAC_QB), .SH(FRAC_SH), .FRAC(1)) u_div_ft (
        .aclk(aclk), .en(en), .num(fx), .den(e_reg), .quo(ft_q));

    scp_dly #(.W(SW), .N(21)) u_dly_b (.aclk(aclk), .en(en), .d(b_reg), .q(b_d));
    scp_dly #(.W(SW), .N(24)) u_dly_f (.aclk(aclk), .en(en), .d(f_reg), .q(f_d));
    scp_dly #(.W(SW), .N(25)) u_dly_e (.aclk(aclk), .en(en), .d(e_reg), .q(e_d));
    scp_dly #(.W(2), .N(43)) u_dly_deg (
        .aclk(aclk), .en(en), .d({a_reg == '0, e_reg == '0}), .q(deg_d));

    // t from the quantised s
    assign s_ext = SW'(s_q);
    scp_mul #(.W(SW)) u_mul_bs (.aclk(aclk), .en(en), .a(b_d), .b(s_ext), .p(bs_p));

    always_ff @(posedge aclk) begin
        if (en) begin
            tn_reg <= NWIDE'(bs_p) + (NWIDE'(f_d) <<< FRAC_SH);
        end
    end

    assign elim  = NWIDE'(e_d) <<< FRAC_SH;
    assign tflag = {tn_reg[NWIDE-1], tn_reg > elim};

    scp_div #(.NW(NWIDE), .DW(SW), .QB(T_QB), .SH(0), .FRAC(0)) u_div_t (
        .aclk(aclk), .en(en), .num(tn_reg), .den(e_d), .quo(t_q));

    scp_dly #(.W(2), .N(18)) u_dly_tf (.aclk(aclk), .en(en), .d(tflag), .q(tflag_d));
    scp_dly #(.W(PARAM_W), .N(22)) u_dly_s (.aclk(aclk), .en(en), .d(s_q), .q(s_d));
    scp_dly #(.W(PARAM_W), .N(26)) u_dly_fc (.aclk(aclk), .en(en), .d(fc_q), .q(fc_d));
    scp_dly #(.W(PARAM_W), .N(26)) u_dly_fbc (.aclk(aclk), .en(en), .d(fbc_q), .q(fbc_d));
    scp_dly #(.W(PARAM_W), .N(26)) u_dly_ft (.aclk(aclk), .en(en), .d(ft_q), .q(ft_d));

    // degenerate and clamp selection
    always_comb begin
        if (deg_d[1] && deg_d[0]) begin
            s_sel = '0;
            t_sel = '0;
        end else if (deg_d[1]) begin
            s_sel = '0;
            t_sel = ft_d;
        end else if (deg_d[0]) begin
            s_sel = fc_d;
            t_sel = '0;
        end else if (tflag_d[1]) begin
            s_sel = fc_d;
            t_sel = '0;
        end else if (tflag_d[0]) begin
            s_sel = fbc_d;
            t_sel = PARAM_ONE;
        end else begin
            s_sel = s_d;
            t_sel = t_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_out_reg <= s_sel;
            t_out_reg <= t_sel;
        end
    end

    assign m_valid        = v_reg[PIPE_LEN-1];
    assign m_param_first  = s_out_reg;
    assign m_param_second = t_out_reg;
endmodule
`default_nettype wire

// ----- sv/scp_dly.sv -----
// enabled delay line for payload alongside the pipeline
`default_nettype none
module scp_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);
    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];
endmodule
`default_nettype wire

// ----- sv/scp_mul.sv -----
// three stage signed multiplier built from four half width partial products
`default_nettype none
module scp_mul #(
    parameter int W = 52
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [W-1:0]   a,
    input  wire logic signed [W-1:0]   b,
    output logic signed      [2*W-1:0] p
);
    localparam int H = (W + 1) / 2;
    localparam int P = 4 * H;

    logic [W-1:0]   ma, mb;
    logic [2*H-1:0] ma_reg, mb_reg;
    logic           neg_reg, neg2_reg;
    logic [2*H-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [P-1:0]   full;
    logic [P-1:0]   res;
    logic signed [2*W-1:0] p_reg;

    assign ma = a[W-1] ? W'(-a) : W'(a);
    assign mb = b[W-1] ? W'(-b) : W'(b);

    always_comb begin
        full = (P'(hh_reg) << (2*H)) + (P'(lh_reg) << H) + (P'(hl_reg) << H) + P'(ll_reg);
        res  = neg2_reg ? -full : full;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= (2*H)'(ma);
            mb_reg   <= (2*H)'(mb);
            neg_reg  <= a[W-1] ^ b[W-1];
            ll_reg   <= ma_reg[H-1:0]   * mb_reg[H-1:0];
            lh_reg   <= ma_reg[H-1:0]   * mb_reg[2*H-1:H];
            hl_reg   <= ma_reg[2*H-1:H] * mb_reg[H-1:0];
            hh_reg   <= ma_reg[2*H-1:H] * mb_reg[2*H-1:H];
            neg2_reg <= neg_reg;
            p_reg    <= (2*W)'(res);
        end
    end

    assign p = p_reg;
endmodule
`default_nettype wire

// ----- sv/scp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with clamp to [0,1] (upper clamp only when FRAC is set)
`default_nettype none
module scp_div #(
    parameter int NW   = 53,
    parameter int DW   = 52,
    parameter int QB   = 16,
    parameter int SH   = 16,
    parameter int FRAC = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [NW-1:0]          num,
    input  wire logic signed [DW-1:0]          den,
    output logic [scp_pkg::PARAM_W-1:0]        quo
);
    import scp_pkg::*;

    localparam int RW = (NW + SH > DW + QB) ? NW + SH : DW + QB;

    logic [RW-1:0]        rem_reg [QB+1];
    logic signed [DW-1:0] den_reg [QB+1];
    logic [QB-1:0]        q_reg   [QB+1];
    logic [QB:0]          zero_reg, one_reg;
    logic [RW-1:0]        dsh [QB];
    logic                 nonpos, sat;

    assign nonpos = num[NW-1] || (num == '0);
    assign sat    = (FRAC != 0) && !nonpos && (num >= den);

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            dsh[k] = RW'($unsigned(den_reg[k])) << (QB - 1 - k);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= RW'($unsigned(num)) << SH;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            zero_reg[0] <= nonpos;
            one_reg[0]  <= sat;
            for (int k = 0; k < QB; k++) begin
                if (rem_reg[k] >= dsh[k]) begin
                    rem_reg[k+1] <= rem_reg[k] - dsh[k];
                    q_reg[k+1]   <= q_reg[k] | (QB'(1) << (QB - 1 - k));
                end else begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
                den_reg[k+1]  <= den_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                one_reg[k+1]  <= one_reg[k];
            end
        end
    end

    assign quo = one_reg[QB]  ? PARAM_ONE :
                 zero_reg[QB] ? '0 : PARAM_W'(q_reg[QB]);
endmodule
`default_nettype wire

// ----- sim/scp_checker.sv -----
// checker for the segment closest points block: predicts s and t and compares
`default_nettype none
module scp_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic signed [scp_pkg::CW-1:0] p1x, p1y, p1z, q1x, q1y, q1z,
    input  wire logic signed [scp_pkg::CW-1:0] p2x, p2y, p2z, q2x, q2y, q2z,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [scp_pkg::PARAM_W-1:0]   m_param_first,
    input  wire logic [scp_pkg::PARAM_W-1:0]   m_param_second,
    output int                                 fail_count,
    output int                                 pending
);
    import scp_pkg::*;

    typedef struct packed {
        logic [PARAM_W-1:0] s;
        logic [PARAM_W-1:0] t;
    } param_pair_t;

    param_pair_t params_due[$];

    assign pending = params_due.size();

    // clamped fraction n/d in Q1.16
    function automatic logic [PARAM_W-1:0] clamp_frac(logic signed [159:0] n,
                                                      logic signed [159:0] d);
        logic signed [159:0] q;
        if (n <= 0) return '0;
        if (n >= d) return PARAM_ONE;
        q = (n <<< 16) / d;
        return q[PARAM_W-1:0];
    endfunction

    function automatic param_pair_t closest_params(
        logic signed [CW-1:0] ax, ay, az, bx, by, bz,
        logic signed [CW-1:0] cx, cy, cz, dx, dy, dz);
        logic signed [159:0] d1 [3];
        logic signed [159:0] d2 [3];
        logic signed [159:0] r [3];
        logic signed [159:0] a, e, f, c, b, denom, tn, sv;
        param_pair_t res;
        d1[0] = bx - ax; d1[1] = by - ay; d1[2] = bz - az;
        d2[0] = dx - cx; d2[1] = dy - cy; d2[2] = dz - cz;
        r[0]  = ax - cx; r[1]  = ay - cy; r[2]  = az - cz;
        a = 0; e = 0; f = 0; c = 0; b = 0;
        for (int k = 0; k < 3; k++) begin
            a += d1[k] * d1[k];
            e += d2[k] * d2[k];
            f += d2[k] * r[k];
            c += d1[k] * r[k];
            b += d1[k] * d2[k];
        end
        if (a == 0 && e == 0) begin
            res.s = '0; res.t = '0;
        end else if (a == 0) begin
            res.s = '0; res.t = clamp_frac(f, e);
        end else if (e == 0) begin
            res.t = '0; res.s = clamp_frac(-c, a);
        end else begin
            denom = a * e - b * b;
            res.s = (denom <= 0) ? '0 : clamp_frac(b * f - c * e, denom);
            sv = res.s;
            tn = b * sv + (f <<< 16);
            if (tn < 0) begin
                res.t = '0; res.s = clamp_frac(-c, a);
            end else if (tn > (e <<< 16)) begin
                res.t = PARAM_ONE; res.s = clamp_frac(b - c, a);
            end else begin
                sv = tn / e;
                res.t = sv[PARAM_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        param_pair_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                params_due.insert(params_due.size(),
                                  closest_params(p1x, p1y, p1z, q1x, q1y, q1z,
                                                 p2x, p2y, p2z, q2x, q2y, q2z));
            if (m_valid && m_ready) begin
                if (params_due.size() == 0) begin
                    $display("%0t: unexpected word s=%0d t=%0d", $time,
                             m_param_first, m_param_second);
                    errs++;
                end else begin
                    want = params_due.pop_front();
                    if (want.s !== m_param_first) begin
                        $display("%0t: param_first expected %0d actual %0d", $time,
                                 want.s, m_param_first);
                        errs++;
                    end
                    if (want.t !== m_param_second) begin
                        $display("%0t: param_second expected %0d actual %0d", $time,
                                 want.t, m_param_second);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// stimulus and verdict for the segment closest points block
`default_nettype none
module tb_top;
    import scp_pkg::*;

    localparam int N_RANDOM = 1830;

    typedef logic signed [CW-1:0] coord_t;

    logic   aclk, aresetn, s_valid, s_ready, m_valid, m_ready;
    coord_t co [12];
    logic [PARAM_W-1:0] m_param_first, m_param_second;
    int     fail_count, pending;
    bit     calm, hold_rx;
    int     rx_gap;

    segment_closest_points u_top (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_seg1_start_x(co[0]), .s_seg1_start_y(co[1]), .s_seg1_start_z(co[2]),
        .s_seg1_end_x(co[3]),   .s_seg1_end_y(co[4]),   .s_seg1_end_z(co[5]),
        .s_seg2_start_x(co[6]), .s_seg2_start_y(co[7]), .s_seg2_start_z(co[8]),
        .s_seg2_end_x(co[9]),   .s_seg2_end_y(co[10]),  .s_seg2_end_z(co[11]),
        .m_valid, .m_ready, .m_param_first, .m_param_second
    );

    scp_checker u_chk (
        .aclk, .aresetn, .s_valid, .s_ready,
        .p1x(co[0]), .p1y(co[1]), .p1z(co[2]), .q1x(co[3]), .q1y(co[4]), .q1z(co[5]),
        .p2x(co[6]), .p2y(co[7]), .p2z(co[8]), .q2x(co[9]), .q2y(co[10]), .q2z(co[11]),
        .m_valid, .m_ready, .m_param_first, .m_param_second, .fail_count, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("segment_closest_points verification failed");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off, none when calm
    initial begin
        m_ready = 1'b0;
        rx_gap  = 0;
        hold_rx = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
            default: return coord_t'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // one word, held until accepted
    task automatic send_word(coord_t w [12]);
        for (int k = 0; k < 12; k++) co[k] <= w[k];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // random pair with a bias to degenerate, parallel and boundary shapes
    task automatic rand_pair(output coord_t w [12]);
        int mode, shape;
        coord_t dd [3];
        mode  = $urandom_range(0, 3);
        shape = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++) w[k] = rand_coord(mode);
        for (int k = 0; k < 3; k++) dd[k] = rand_coord(1);
        case (shape)
            0: for (int k = 0; k < 3; k++) w[3+k] = w[k];
            1: for (int k = 0; k < 3; k++) w[9+k] = w[6+k];
            2: for (int k = 0; k < 3; k++) begin
                w[3+k] = w[k] + dd[k];
                w[9+k] = w[6+k] - dd[k];
            end
            3: for (int k = 0; k < 3; k++) begin
                w[3+k] = w[k] + dd[k];
                w[9+k] = w[6+k] + (dd[k] <<< 1);
            end
            default: ;
        endcase
    endtask

    initial begin
        coord_t w [12];
        calm    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        for (int k = 0; k < 12; k++) co[k] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, degenerate, parallel, crossing, clamps, then random pairs
        for (int n = 0; n < 20; n++) begin
            for (int k = 0; k < 12; k++) w[k] = '0;
            case (n)
                0: ;
                1: for (int k = 0; k < 12; k++) w[k] = coord_t'(24'h7fffff);
                2: for (int k = 0; k < 12; k++) w[k] = (k % 2) ? 24'h800000 : 24'h7fffff;
                3: begin w[9] = 24'sd65536; end
                4: begin w[3] = 24'sd65536; w[6] = 24'sd32768; w[7] = 24'sd5; end
                5: begin w[3] = 24'sd65536; w[9] = 24'sd65536; w[7] = 24'sd65536; end
                6: begin
                    w[3] = 24'sd65536; w[6] = 24'sd32768; w[7] = -24'sd65536;
                    w[10] = 24'sd65536;
                end
                7: begin
                    w[3] = 24'sd65536; w[6] = 24'sd200000; w[7] = -24'sd65536;
                    w[10] = 24'sd65536;
                end
                8: begin
                    w[3] = 24'sd65536; w[6] = -24'sd200000; w[7] = -24'sd65536;
                    w[10] = 24'sd65536;
                end
                9: begin
                    w[3] = 24'sd65536; w[6] = 24'sd30000; w[7] = 24'sd100000;
                    w[10] = 24'sd300000;
                end
                10: begin
                    w[3] = 24'sd65536; w[6] = 24'sd30000; w[7] = -24'sd400000;
                    w[10] = -24'sd300000;
                end
                11: begin
                    w[0] = 24'h800000; w[3] = 24'h7fffff;
                    w[7] = 24'h800000; w[10] = 24'h7fffff; w[8] = 24'h7fffff;
                end
                12: begin w[3] = 24'h7fffff; w[9] = 24'h800000; end
                13: begin w[3] = 24'sd65536; w[9] = -24'sd65536; end
                default: rand_pair(w);
            endcase
            send_word(w);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) begin
                // long receiver hold-off while words keep coming
                hold_rx = 1'b1;
                fork
                    begin repeat (150) @(posedge aclk); hold_rx = 1'b0; end
                join_none
            end
            if (n == 900) begin
                // sender waits for the pipeline to drain
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            if (n == N_RANDOM - 200) calm = 1'b1;
            sender_gap();
            rand_pair(w);
            send_word(w);
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (PIPE_LEN + 20) @(posedge aclk);
        if (fail_count == 0)
            $display("segment_closest_points verification clean");
        else
            $display("segment_closest_points verification failed");
        $finish;
    end
endmodule
`default_nettype wire
